>>> design/ssin_pkg.sv
// Shared types and constants for the series sine evaluator.
package ssin_pkg;

  localparam int ANGLE_W    = 31;
  localparam int SINE_W     = 31;
  localparam int TERMS_W    = 6;
  localparam int TOL_W      = 30;
  localparam int MAG_W      = 30;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int X2_W       = 30;
  localparam int TERM_W     = 33;
  localparam int PROD_W     = TERM_W + X2_W;
  localparam int SUM_W      = 35;
  localparam int DEN_W      = 12;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = 10;
  localparam int NUM_W      = DIV_BITS * DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [MAG_W-1:0]     PI_Q28    = 30'd843314857;
  localparam logic [TERMS_W-1:0]   TERM_CAP  = 6'd32;
  localparam logic [SINE_W-1:0]    ONE_Q29   = 31'd536870912;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TERMS = 2'd1;

  typedef struct packed {
    logic load;
    logic square;
    logic init;
    logic check;
    logic mul;
    logic num;
    logic div;
    logic upd;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic term_small;
    logic at_limit;
  } sts_t;

endpackage

>>> design/ssin_ctrl.sv
// Sequencer for the series sine evaluator: term loop, divider steps, output handshake.
module ssin_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  ssin_pkg::sts_t  sts,
  output ssin_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INIT,
    ST_CHECK,
    ST_MUL,
    ST_NUM,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_t;

  state_t                           state_r;
  logic [ssin_pkg::DIV_CNT_W-1:0]   div_cnt_r;
  logic                             out_valid_r;
  logic                             out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:   cmd.load   = in_tvalid;
      ST_SQUARE: cmd.square = 1'b1;
      ST_INIT:   cmd.init   = 1'b1;
      ST_CHECK:  cmd.check  = 1'b1;
      ST_MUL:    cmd.mul    = 1'b1;
      ST_NUM:    cmd.num    = 1'b1;
      ST_DIV:    cmd.div    = 1'b1;
      ST_UPD:    cmd.upd    = 1'b1;
      ST_FIN:    cmd.fin    = out_free;
      default:   cmd        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: state_r <= ST_INIT;
        ST_INIT:   state_r <= ST_CHECK;
        ST_CHECK: begin
          if (sts.term_small || sts.at_limit) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL:    state_r <= ST_NUM;
        ST_NUM: begin
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_cnt_r == ssin_pkg::DIV_CNT_W'(ssin_pkg::DIV_STEPS - 1)) begin
            state_r <= ST_UPD;
          end else begin
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        ST_UPD:    state_r <= ST_CHECK;
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/ssin_dp.sv
// Datapath for the series sine evaluator: square, term recurrence, divider, final rounding.
module ssin_dp (
  input  logic                              clk,
  input  ssin_pkg::cmd_t                    cmd,
  output ssin_pkg::sts_t                    sts,
  input  logic signed [ssin_pkg::ANGLE_W-1:0] angle,
  input  logic [ssin_pkg::TOL_W-1:0]        tolerance,
  input  logic [ssin_pkg::TERMS_W-1:0]      max_terms,
  output logic signed [ssin_pkg::SINE_W-1:0] sine_value,
  output logic [ssin_pkg::TERMS_W-1:0]      terms_used,
  output logic                              converged,
  output logic                              range_clipped
);

  logic [ssin_pkg::MAG_W-1:0]    a_r;
  logic                          neg_r;
  logic                          clip_r;
  logic [ssin_pkg::TERMS_W-1:0]  limit_r;
  logic [ssin_pkg::SQ_W-1:0]     sq_r;
  logic [ssin_pkg::X2_W-1:0]     x2_r;
  logic [ssin_pkg::TERM_W-1:0]   t_r;
  logic signed [ssin_pkg::SUM_W-1:0] sum_r;
  logic [ssin_pkg::TERMS_W-1:0]  k_r;
  logic                          conv_r;
  logic [ssin_pkg::PROD_W-1:0]   p_r;
  logic [ssin_pkg::DEN_W-1:0]    d_r;
  logic [ssin_pkg::NUM_W-1:0]    num_r;
  logic [ssin_pkg::DEN_W-1:0]    rem_r;

  logic signed [ssin_pkg::SINE_W-1:0] sine_r;
  logic [ssin_pkg::TERMS_W-1:0]  terms_r;
  logic                          conv_out_r;
  logic                          clip_out_r;

  // input magnitude and saturation
  logic                          in_neg;
  logic [31:0]                   in_abs;
  logic                          in_clip;
  logic [ssin_pkg::MAG_W-1:0]    in_mag;
  logic [ssin_pkg::TERMS_W-1:0]  in_limit;

  always_comb begin
    in_neg  = angle[ssin_pkg::ANGLE_W-1];
    in_abs  = in_neg ? (32'h8000_0000 - {1'b0, angle}) : {1'b0, angle};
    in_clip = in_abs > {2'b00, ssin_pkg::PI_Q28};
    in_mag  = in_clip ? ssin_pkg::PI_Q28 : in_abs[ssin_pkg::MAG_W-1:0];
    if (max_terms == '0) begin
      in_limit = ssin_pkg::TERMS_W'(1);
    end else if (max_terms > ssin_pkg::TERM_CAP) begin
      in_limit = ssin_pkg::TERM_CAP;
    end else begin
      in_limit = max_terms;
    end
  end

  // denominator 2k(2k+1)
  logic [6:0]  k2;
  logic [13:0] den_full;
  assign k2       = {k_r, 1'b0};
  assign den_full = 14'(k2) * 14'(k2 + 7'd1);

  // four quotient bits per step
  logic [ssin_pkg::DEN_W:0]      rem_w [ssin_pkg::DIV_BITS+1];
  logic [ssin_pkg::NUM_W-1:0]    num_w [ssin_pkg::DIV_BITS+1];
  logic [ssin_pkg::DEN_W:0]      trial;

  always_comb begin
    rem_w[0] = {1'b0, rem_r};
    num_w[0] = num_r;
    trial    = '0;
    for (int i = 0; i < ssin_pkg::DIV_BITS; i++) begin
      trial = {rem_w[i][ssin_pkg::DEN_W-1:0], num_w[i][ssin_pkg::NUM_W-1]};
      if (trial >= {1'b0, d_r}) begin
        rem_w[i+1] = trial - {1'b0, d_r};
        num_w[i+1] = {num_w[i][ssin_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_w[i+1] = trial;
        num_w[i+1] = {num_w[i][ssin_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  // final rounding and clamp
  logic                          sum_neg;
  logic [ssin_pkg::SUM_W-1:0]    sum_mag;
  logic [ssin_pkg::SUM_W-1:0]    rnd;
  logic [ssin_pkg::SINE_W-1:0]   rnd_clamp;
  logic [ssin_pkg::SINE_W-1:0]   fin_val;
  logic signed [ssin_pkg::SUM_W-1:0] q_ext;

  always_comb begin
    sum_neg   = sum_r[ssin_pkg::SUM_W-1];
    sum_mag   = sum_neg ? ssin_pkg::SUM_W'(-sum_r) : ssin_pkg::SUM_W'(sum_r);
    rnd       = (sum_mag + ssin_pkg::SUM_W'(1)) >> 1;
    rnd_clamp = (rnd > ssin_pkg::SUM_W'(ssin_pkg::ONE_Q29)) ? ssin_pkg::ONE_Q29
                                                            : rnd[ssin_pkg::SINE_W-1:0];
    fin_val   = (sum_neg ^ neg_r) ? (ssin_pkg::SINE_W'(0) - rnd_clamp) : rnd_clamp;
    q_ext     = $signed({2'b00, num_r[ssin_pkg::TERM_W-1:0]});
  end

  assign sts.term_small = t_r <= {2'b00, tolerance, 1'b0};
  assign sts.at_limit   = k_r >= limit_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r     <= in_mag;
      neg_r   <= in_neg;
      clip_r  <= in_clip;
      limit_r <= in_limit;
    end
    if (cmd.square) begin
      sq_r <= a_r * a_r;
    end
    if (cmd.init) begin
      x2_r  <= ssin_pkg::X2_W'(({1'b0, sq_r} + (61'(1) << 29)) >> 30);
      t_r   <= {1'b0, a_r, 2'b00};
      sum_r <= $signed({3'b000, a_r, 2'b00});
      k_r   <= ssin_pkg::TERMS_W'(1);
    end
    if (cmd.check) begin
      conv_r <= sts.term_small;
    end
    if (cmd.mul) begin
      p_r <= t_r * x2_r;
      d_r <= den_full[ssin_pkg::DEN_W-1:0];
    end
    if (cmd.num) begin
      num_r <= ssin_pkg::NUM_W'(({1'b0, p_r} + {27'd0, d_r, 25'd0}) >> 26);
      rem_r <= '0;
    end
    if (cmd.div) begin
      num_r <= num_w[ssin_pkg::DIV_BITS];
      rem_r <= rem_w[ssin_pkg::DIV_BITS][ssin_pkg::DEN_W-1:0];
    end
    if (cmd.upd) begin
      t_r <= num_r[ssin_pkg::TERM_W-1:0];
      k_r <= k_r + 1'b1;
      if (!k_r[0]) begin
        sum_r <= sum_r + q_ext;
      end else begin
        sum_r <= sum_r - q_ext;
      end
    end
    if (cmd.fin) begin
      sine_r     <= fin_val;
      terms_r    <= k_r;
      conv_out_r <= conv_r;
      clip_out_r <= clip_r;
    end
  end

  assign sine_value    = sine_r;
  assign terms_used    = terms_r;
  assign converged     = conv_out_r;
  assign range_clipped = clip_out_r;

endmodule

>>> design/series_sine_evaluator.sv
// Top level of the series sine evaluator: ports, configuration registers, sequencer and datapath.
//
//   channel | dir | handshake              | word
//   in_     | in  | in_tvalid / in_tready   | angle (Q3.28)
//   out_    | out | out_tvalid / out_tready | sine, terms used, converged, clipped
//   cfg_    | in  | cfg_we                  | register index, write data
//
// An item sums n terms (n = 1..32); each extra term costs one multiply, one setup
// step, ten radix-16 divider steps, one update and one check. A finished word waits in
// the output register; the next angle is taken meanwhile, and that item stalls at its
// last cycle until the register frees. rst_n clears control state and sets tolerance
// to 1 and max_terms to 16.
module series_sine_evaluator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ssin_pkg::IN_DATA_W-1:0]      in_tdata,   // [30:0] angle
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ssin_pkg::OUT_DATA_W-1:0]     out_tdata,  // [30:0] sine_value,
                                                          // [36:31] terms_used,
                                                          // [37] converged,
                                                          // [38] range_clipped
  input  logic                                cfg_we,
  input  logic [ssin_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssin_pkg::TOL_W-1:0]          cfg_wdata
);

  logic [ssin_pkg::TOL_W-1:0]     tolerance_r;
  logic [ssin_pkg::TERMS_W-1:0]   max_terms_r;
  ssin_pkg::cmd_t                 cmd;
  ssin_pkg::sts_t                 sts;
  logic signed [ssin_pkg::SINE_W-1:0] sine_value;
  logic [ssin_pkg::TERMS_W-1:0]   terms_used;
  logic                           converged;
  logic                           range_clipped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= ssin_pkg::TOL_W'(1);
      max_terms_r <= ssin_pkg::TERMS_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssin_pkg::REG_TOLERANCE: tolerance_r <= cfg_wdata;
        ssin_pkg::REG_MAX_TERMS: max_terms_r <= cfg_wdata[ssin_pkg::TERMS_W-1:0];
        default: ;
      endcase
    end
  end

  ssin_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ssin_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .angle         ($signed(in_tdata[ssin_pkg::ANGLE_W-1:0])),
    .tolerance     (tolerance_r),
    .max_terms     (max_terms_r),
    .sine_value    (sine_value),
    .terms_used    (terms_used),
    .converged     (converged),
    .range_clipped (range_clipped)
  );

  assign out_tdata = {1'b0, range_clipped, converged, terms_used, sine_value};

endmodule

>>> bench/series_sine_evaluator_test.sv
// Testbench for series_sine_evaluator: random angle stream under many register settings.
`timescale 1ns / 1ps

module series_sine_evaluator_test;

  localparam logic [ssin_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [ssin_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 450;
  localparam int PHASES = 9;

  typedef struct packed {
    logic [ssin_pkg::SINE_W-1:0]  sine_value;
    logic [ssin_pkg::TERMS_W-1:0] terms_used;
    logic                         converged;
    logic                         range_clipped;
  } sine_word_t;

  class sine_scoreboard;
    logic [ssin_pkg::TOL_W-1:0]   tolerance = 30'd1;
    logic [ssin_pkg::TERMS_W-1:0] term_limit = 6'd16;
    sine_word_t         pending_sines[$];
    int error_count = 0;
    int words_checked = 0;
    int clipped_words = 0;
    int converged_words = 0;
    int limit_words = 0;
    int saturated_words = 0;

    function void write_reg(logic [ssin_pkg::CFG_IDX_W-1:0] index,
                            logic [ssin_pkg::TOL_W-1:0] value);
      if (index == ssin_pkg::REG_TOLERANCE)
        tolerance = value;
      else if (index == ssin_pkg::REG_MAX_TERMS)
        term_limit = value[ssin_pkg::TERMS_W-1:0];
    endfunction

    function sine_word_t predict_sine(logic [ssin_pkg::ANGLE_W-1:0] angle);
      sine_word_t w;
      logic [63:0] mag_in, x2, t, thr, mag, r, den;
      logic signed [63:0] sum, v, one;
      int unsigned k, lim;
      logic neg, clip, conv;
      one = longint'(ssin_pkg::ONE_Q29);
      neg = angle[ssin_pkg::ANGLE_W-1];
      mag_in = neg ? (64'h8000_0000 - 64'(angle)) : 64'(angle);
      clip = mag_in > 64'(ssin_pkg::PI_Q28);
      if (clip) mag_in = 64'(ssin_pkg::PI_Q28);
      lim = term_limit;
      if (lim < 1) lim = 1;
      if (lim > 32'(ssin_pkg::TERM_CAP)) lim = 32'(ssin_pkg::TERM_CAP);
      x2 = (mag_in * mag_in + (64'd1 << 29)) >> 30;
      t = mag_in << 2;
      sum = $signed(t);
      thr = 64'(tolerance) << 1;
      k = 1;
      conv = (t <= thr);
      while (!conv && k < lim) begin
        den = 64'((2 * k) * (2 * k + 1)) << 26;
        t = (t * x2 + (den >> 1)) / den;
        k++;
        if (k % 2 == 1)
          sum = sum + $signed(t);
        else
          sum = sum - $signed(t);
        conv = (t <= thr);
      end
      mag = (sum < 0) ? 64'(-sum) : 64'(sum);
      r = (mag + 1) >> 1;
      v = ((sum < 0) != neg) ? -$signed(r) : $signed(r);
      if (v > one) v = one;
      if (v < -one) v = -one;
      w.sine_value = v[ssin_pkg::SINE_W-1:0];
      w.terms_used = k[ssin_pkg::TERMS_W-1:0];
      w.converged = conv;
      w.range_clipped = clip;
      return w;
    endfunction

    function void note_angle(logic [ssin_pkg::ANGLE_W-1:0] angle);
      pending_sines.push_back(predict_sine(angle));
    endfunction

    function int pending_count();
      return pending_sines.size();
    endfunction

    function void check_word(logic [ssin_pkg::OUT_DATA_W-1:0] data);
      sine_word_t got, want;
      got = {data[ssin_pkg::SINE_W-1:0],
             data[ssin_pkg::SINE_W+ssin_pkg::TERMS_W-1:ssin_pkg::SINE_W],
             data[ssin_pkg::SINE_W+ssin_pkg::TERMS_W],
             data[ssin_pkg::SINE_W+ssin_pkg::TERMS_W+1]};
      if (pending_sines.size() == 0) begin
        $error("sine word 0x%h arrived with no angle outstanding", data);
        error_count++;
        return;
      end
      want = pending_sines.pop_front();
      words_checked++;
      if (got.sine_value != want.sine_value) begin
        $error("sine_value expected %0d got %0d", $signed(want.sine_value),
               $signed(got.sine_value));
        error_count++;
      end
      if (got.terms_used != want.terms_used) begin
        $error("terms_used expected %0d got %0d", want.terms_used, got.terms_used);
        error_count++;
      end
      if (got.converged != want.converged) begin
        $error("converged expected %0d got %0d", want.converged, got.converged);
        error_count++;
      end
      if (got.range_clipped != want.range_clipped) begin
        $error("range_clipped expected %0d got %0d", want.range_clipped, got.range_clipped);
        error_count++;
      end
      if (want.range_clipped) clipped_words++;
      if (want.converged) converged_words++;
      else limit_words++;
      if (want.sine_value == ssin_pkg::ONE_Q29 ||
          want.sine_value == ssin_pkg::SINE_W'(-ssin_pkg::ONE_Q29))
        saturated_words++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [ssin_pkg::IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [ssin_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_we;
  logic [ssin_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ssin_pkg::TOL_W-1:0] cfg_wdata;

  sine_scoreboard sb = new();
  int stalled_cycles = 0;
  bit feed_paced = 1'b1;

  series_sine_evaluator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stalled_cycles <= 0;
    end else begin
      if (in_tvalid && in_tready) sb.note_angle(in_tdata[ssin_pkg::ANGLE_W-1:0]);
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stalled_cycles <= 0;
      else
        stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stalled_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : result_sink
    int stall;
    bit sink_paced;
    sink_paced = 1'b1;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = sink_paced ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if ($urandom_range(0, 49) == 0) sink_paced = !sink_paced;
    end
  end

  // Caller must issue the next angle or drain in the same step as the return.
  task automatic send_angle(input logic [ssin_pkg::ANGLE_W-1:0] angle);
    int gap;
    gap = feed_paced ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ssin_pkg::IN_DATA_W'(angle);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(0, 39) == 0) feed_paced = !feed_paced;
  endtask

  task automatic drain_sines();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [ssin_pkg::TOL_W-1:0] tol,
                                input logic [ssin_pkg::TOL_W-1:0] lim);
    logic [ssin_pkg::CFG_IDX_W-1:0] spare;
    logic [ssin_pkg::TOL_W-1:0] junk;
    spare = $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
    junk = ssin_pkg::TOL_W'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= ssin_pkg::REG_TOLERANCE;
    cfg_wdata <= tol;
    sb.write_reg(ssin_pkg::REG_TOLERANCE, tol);
    @(posedge clk);
    cfg_index <= ssin_pkg::REG_MAX_TERMS;
    cfg_wdata <= lim;
    sb.write_reg(ssin_pkg::REG_MAX_TERMS, lim);
    @(posedge clk);
    cfg_index <= spare;
    cfg_wdata <= junk;
    sb.write_reg(spare, junk);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ssin_pkg::ANGLE_W-1:0] random_angle();
    int unsigned pick;
    logic [ssin_pkg::ANGLE_W-1:0] mag;
    pick = $urandom_range(0, 19);
    if (pick < 3)
      return ssin_pkg::ANGLE_W'($urandom);
    if (pick < 6)
      mag = ssin_pkg::ANGLE_W'($urandom_range(0, 1 << 18));
    else
      mag = ssin_pkg::ANGLE_W'($urandom_range(0, int'(ssin_pkg::PI_Q28)));
    return $urandom_range(0, 1) ? ssin_pkg::ANGLE_W'(0) - mag : mag;
  endfunction

  localparam logic [ssin_pkg::ANGLE_W-1:0] CORNER_ANGLES [14] = '{
    31'(ssin_pkg::PI_Q28 >> 1), 31'(-(ssin_pkg::PI_Q28 >> 1)), 31'(ssin_pkg::PI_Q28),
    31'h4000_0000, 31'd0, 31'd1, 31'h7FFF_FFFF, 31'(ssin_pkg::PI_Q28) + 31'd1,
    31'(-int'(ssin_pkg::PI_Q28)), 31'(-int'(ssin_pkg::PI_Q28) - 1), 31'h3FFF_FFFF,
    31'd268435456, 31'd16, 31'h7FFF_FFF0
  };

  initial begin : stimulus
    logic [ssin_pkg::TOL_W-1:0] tol_plan [PHASES];
    logic [ssin_pkg::TOL_W-1:0] limit_plan [PHASES];
    int count_plan [PHASES];
    int p;
    tol_plan   = '{30'd0, 30'd0, 30'd536870912, 30'h3FFF_FFFF, 30'd0, 30'd100, 30'd1,
                   ssin_pkg::TOL_W'($urandom_range(0, 1 << 20)),
                   ssin_pkg::TOL_W'($urandom_range(0, 1 << 16))};
    limit_plan = '{30'd32, 30'd1, 30'd16, 30'd5, 30'd0, 30'd63, 30'd16,
                   ssin_pkg::TOL_W'($urandom_range(1, 32)),
                   ssin_pkg::TOL_W'($urandom_range(0, 63))};
    count_plan = '{90, 60, 60, 50, 50, 80, 80, 90, 90};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= ssin_pkg::REG_TOLERANCE;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (CORNER_ANGLES[i]) send_angle(CORNER_ANGLES[i]);
    drain_sines();
    for (p = 0; p < PHASES; p++) begin
      apply_settings(tol_plan[p], limit_plan[p]);
      for (int i = 0; i < 4; i++) send_angle(CORNER_ANGLES[i]);
      repeat (count_plan[p]) send_angle(random_angle());
      drain_sines();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d sine words over %0d register settings; %0d clipped angles,",
             sb.words_checked, PHASES + 1, sb.clipped_words);
    $display("%0d converged, %0d stopped at the term limit, %0d saturated at +-1.0.",
             sb.converged_words, sb.limit_words, sb.saturated_words);
    if (sb.error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
